// ----- rtl/ptq_pkg.sv -----
package ptq_pkg;

    localparam int REQ_W       = 3;
    localparam int BYTE_W      = 8;
    localparam int STAT_W      = 2;
    localparam int COUNT_W     = 5;
    localparam int MAXP_W      = 5;
    localparam int TOTAL_W     = 32;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 120;

    // request codes as they arrive on the slave-side tuser
    localparam logic [REQ_W-1:0] REQ_PUSH  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_START = 3'd1;
    localparam logic [REQ_W-1:0] REQ_TICK  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DONE  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_FLUSH = 3'd4;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd5;

    typedef enum logic [2:0] {
        OP_PUSH  = 3'd0,
        OP_START = 3'd1,
        OP_TICK  = 3'd2,
        OP_DONE  = 3'd3,
        OP_FLUSH = 3'd4,
        OP_CLEAR = 3'd5,
        OP_NOP   = 3'd6
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_REJECT = 2'd1,
        STAT_NONE   = 2'd2,
        STAT_DROP   = 2'd3
    } t_status;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              link;
    } t_cmd;

    typedef struct packed {
        t_status            status;
        logic [COUNT_W-1:0] packet_count;
        logic               none_waiting;
        logic               tx_busy;
        logic [BYTE_W-1:0]  out_byte;
        logic               out_valid;
        logic               out_last;
        logic [TOTAL_W-1:0] push_total;
        logic [TOTAL_W-1:0] pop_total;
        logic [TOTAL_W-1:0] fail_total;
        logic [COUNT_W-1:0] peak_packets;
    } t_result;

endpackage

// ----- rtl/ptq_ram.sv -----
module ptq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                         i_wr_data,
    input  logic                                     i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/ptq_front.sv -----
module ptq_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [ptq_pkg::IN_TDATA_W-1:0]       i_s_tdata,
    input  logic                                 i_s_tlast,
    input  logic [ptq_pkg::REQ_W-1:0]            i_s_tuser,
    output logic                                 o_valid,
    output ptq_pkg::t_cmd                        o_cmd,
    input  logic                                 i_ready
);

    import ptq_pkg::*;

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic take;

    assign o_s_tready = !r_valid || i_ready;
    assign take       = i_s_tvalid && o_s_tready;

    // decode the request code, unused codes become a no-op
    always_comb begin
        n_cmd.data = i_s_tdata[BYTE_W-1:0];
        n_cmd.link = i_s_tdata[BYTE_W];
        n_cmd.last = i_s_tlast;
        unique case (i_s_tuser)
            REQ_PUSH:  n_cmd.op = OP_PUSH;
            REQ_START: n_cmd.op = OP_START;
            REQ_TICK:  n_cmd.op = OP_TICK;
            REQ_DONE:  n_cmd.op = OP_DONE;
            REQ_FLUSH: n_cmd.op = OP_FLUSH;
            REQ_CLEAR: n_cmd.op = OP_CLEAR;
            default:   n_cmd.op = OP_NOP;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (take) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

endmodule

// ----- rtl/ptq_queue.sv -----
module ptq_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ptq_pkg::t_cmd i_cmd,
    output logic          o_in_ready,
    input  logic          i_pop,
    output ptq_pkg::t_cmd o_cmd,
    output logic          o_out_valid
);

    import ptq_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [NW-1:0] r_count;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [NW-1:0] n_count;
    logic          do_push;
    logic          do_pop;

    assign o_in_ready  = (r_count != NW'(DEPTH));
    assign o_out_valid = (r_count != '0);
    assign do_push     = i_push && o_in_ready;
    assign do_pop      = i_pop && o_out_valid;
    assign o_cmd       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ----- rtl/ptq_back.sv -----
module ptq_back #(
    parameter int PACKET_SLOTS = 16,
    parameter int STORE_BYTES  = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [ptq_pkg::MAXP_W-1:0]    i_cfg_wr_data,
    input  logic                          i_q_valid,
    input  ptq_pkg::t_cmd                 i_q_cmd,
    output logic                          o_q_pop,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output ptq_pkg::t_result              o_res
);

    import ptq_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);
    localparam int LW = $clog2(STORE_BYTES + 1);
    localparam int XW = LW + 1;
    localparam int SW = $clog2(PACKET_SLOTS);
    localparam int CW = $clog2(PACKET_SLOTS + 1);
    localparam int KW = (CW > MAXP_W) ? CW : MAXP_W;

    typedef enum logic [1:0] {
        BS_EXEC = 2'b01,
        BS_FIN  = 2'b10
    } t_bstate;

    t_bstate            r_state;
    t_cmd               r_cmd;
    logic [MAXP_W-1:0]  r_max;
    logic [SW-1:0]      r_head, n_head;
    logic [SW-1:0]      r_tail, n_tail;
    logic [CW-1:0]      r_wait, n_wait;
    logic [AW-1:0]      r_wp, n_wp;
    logic [LW-1:0]      r_part, n_part;
    logic [LW-1:0]      r_used, n_used;
    logic               r_busy, n_busy;
    logic [AW-1:0]      r_cur_start, n_cur_start;
    logic [LW-1:0]      r_cur_len, n_cur_len;
    logic [LW-1:0]      r_cur_off, n_cur_off;
    logic [TOTAL_W-1:0] r_push, n_push;
    logic [TOTAL_W-1:0] r_pop, n_pop;
    logic [TOTAL_W-1:0] r_fail, n_fail;
    logic [CW-1:0]      r_peak, n_peak;
    logic               r_res_valid;
    t_result            r_res, n_res;

    t_cmd               cmd_cur;
    logic               need_read;
    logic               out_free;
    logic               issue;
    logic               quick;
    logic               commit;
    logic [KW-1:0]      lim_max;
    logic [KW-1:0]      limit;
    logic               push_full;
    logic [AW-1:0]      wp_inc;
    logic [LW-1:0]      part_inc;
    logic [CW-1:0]      wait_inc;
    logic [SW-1:0]      head_inc;
    logic [SW-1:0]      tail_inc;
    logic [AW-1:0]      part_start;
    logic [AW-1:0]      gap;
    logic [XW-1:0]      rd_sum;
    logic [AW-1:0]      store_rd_addr;
    logic               store_we;
    logic               store_re;
    logic               slot_we;
    logic               slot_re;
    logic [BYTE_W-1:0]  store_rd_data;
    logic [AW+LW-1:0]   slot_rd_data;
    logic [AW-1:0]      slot_start;
    logic [LW-1:0]      slot_len;

    // a - b around the byte ring, b never exceeds the store size
    function automatic logic [AW-1:0] ring_diff(input logic [AW-1:0] a,
                                                input logic [LW-1:0] b);
        logic [XW-1:0] s;
        s = XW'(a) + XW'(STORE_BYTES) - XW'(b);
        if (s >= XW'(STORE_BYTES)) begin
            s = s - XW'(STORE_BYTES);
        end
        return s[AW-1:0];
    endfunction

    assign cmd_cur = (r_state == BS_FIN) ? r_cmd : i_q_cmd;

    always_comb begin
        unique case (cmd_cur.op)
            OP_START: need_read = !r_busy && (r_wait != '0);
            OP_TICK:  need_read = r_busy && (r_cur_off < r_cur_len);
            OP_DONE:  need_read = r_busy && (r_wait != '0);
            default:  need_read = 1'b0;
        endcase
    end

    assign out_free = !r_res_valid || i_res_ready;
    assign issue    = (r_state == BS_EXEC) && i_q_valid && need_read;
    assign quick    = (r_state == BS_EXEC) && i_q_valid && !need_read && out_free;
    assign commit   = quick || ((r_state == BS_FIN) && out_free);
    assign o_q_pop  = issue || quick;

    assign lim_max   = KW'(r_max);
    assign limit     = ((r_max == '0) || (lim_max > KW'(PACKET_SLOTS))) ?
                       KW'(PACKET_SLOTS) : lim_max;
    assign push_full = (KW'(r_wait) >= limit) ||
                       ((XW'(r_used) + XW'(r_part)) >= XW'(STORE_BYTES));

    assign wp_inc     = (r_wp == AW'(STORE_BYTES - 1)) ? '0 : r_wp + 1'b1;
    assign part_inc   = r_part + 1'b1;
    assign wait_inc   = r_wait + 1'b1;
    assign head_inc   = (r_head == SW'(PACKET_SLOTS - 1)) ? '0 : r_head + 1'b1;
    assign tail_inc   = (r_tail == SW'(PACKET_SLOTS - 1)) ? '0 : r_tail + 1'b1;
    assign part_start = ring_diff(r_wp, r_part);

    assign slot_start = slot_rd_data[AW+LW-1:LW];
    assign slot_len   = slot_rd_data[LW-1:0];
    assign gap        = ring_diff(slot_start, LW'(r_cur_start));

    always_comb begin
        rd_sum = XW'(r_cur_start) + XW'(r_cur_off);
        if (rd_sum >= XW'(STORE_BYTES)) begin
            rd_sum = rd_sum - XW'(STORE_BYTES);
        end
        store_rd_addr = rd_sum[AW-1:0];
    end

    assign store_we = commit && (cmd_cur.op == OP_PUSH) && !push_full;
    assign slot_we  = store_we && cmd_cur.last;
    assign store_re = issue && (cmd_cur.op == OP_TICK);
    assign slot_re  = issue && ((cmd_cur.op == OP_START) || (cmd_cur.op == OP_DONE));

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_wait      = r_wait;
        n_wp        = r_wp;
        n_part      = r_part;
        n_used      = r_used;
        n_busy      = r_busy;
        n_cur_start = r_cur_start;
        n_cur_len   = r_cur_len;
        n_cur_off   = r_cur_off;
        n_push      = r_push;
        n_pop       = r_pop;
        n_fail      = r_fail;
        n_peak      = r_peak;
        n_res       = '0;
        n_res.status = STAT_NONE;
        unique case (cmd_cur.op)
            OP_PUSH: begin
                if (push_full) begin
                    // drop the partial packet and rewind the write pointer
                    n_wp         = part_start;
                    n_part       = '0;
                    n_fail       = r_fail + 1'b1;
                    n_res.status = STAT_REJECT;
                end else begin
                    n_wp = wp_inc;
                    if (cmd_cur.last) begin
                        n_tail = tail_inc;
                        n_wait = wait_inc;
                        n_used = r_used + part_inc;
                        n_part = '0;
                        n_push = r_push + 1'b1;
                        if (wait_inc > r_peak) begin
                            n_peak = wait_inc;
                        end
                    end else begin
                        n_part = part_inc;
                    end
                    n_res.status = STAT_OK;
                end
            end
            OP_START: begin
                if (need_read) begin
                    n_head = head_inc;
                    n_wait = r_wait - 1'b1;
                    n_pop  = r_pop + 1'b1;
                    if (cmd_cur.link) begin
                        n_busy       = 1'b1;
                        n_cur_start  = slot_start;
                        n_cur_len    = slot_len;
                        n_cur_off    = '0;
                        n_res.status = STAT_OK;
                    end else begin
                        n_used       = (r_used >= slot_len) ? r_used - slot_len : '0;
                        n_cur_start  = '0;
                        n_res.status = STAT_DROP;
                    end
                end
            end
            OP_TICK: begin
                if (need_read) begin
                    n_res.out_byte  = store_rd_data;
                    n_res.out_valid = 1'b1;
                    n_res.out_last  = ((r_cur_off + 1'b1) == r_cur_len);
                    n_cur_off       = r_cur_off + 1'b1;
                    n_res.status    = STAT_OK;
                end
            end
            OP_DONE: begin
                if (r_busy) begin
                    // free the sent packet plus any flushed ones behind it
                    if (r_wait == '0) begin
                        n_used = '0;
                    end else begin
                        n_used = (r_used >= LW'(gap)) ? r_used - LW'(gap) : '0;
                    end
                    n_busy       = 1'b0;
                    n_cur_start  = '0;
                    n_cur_len    = '0;
                    n_cur_off    = '0;
                    n_res.status = STAT_OK;
                end
            end
            OP_FLUSH: begin
                n_pop  = r_pop + TOTAL_W'(r_wait);
                n_wait = '0;
                n_head = r_tail;
                if (!r_busy) begin
                    n_used = '0;
                end
                n_res.status = STAT_OK;
            end
            OP_CLEAR: begin
                n_push       = '0;
                n_pop        = '0;
                n_fail       = '0;
                n_peak       = '0;
                n_res.status = STAT_OK;
            end
            default: begin
                n_res.status = STAT_NONE;
            end
        endcase
        n_res.packet_count = COUNT_W'(n_wait);
        n_res.none_waiting = (n_wait == '0);
        n_res.tx_busy      = n_busy;
        n_res.push_total   = n_push;
        n_res.pop_total    = n_pop;
        n_res.fail_total   = n_fail;
        n_res.peak_packets = COUNT_W'(n_peak);
    end

    ptq_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (store_we),
        .i_wr_addr (r_wp),
        .i_wr_data (cmd_cur.data),
        .i_rd_en   (store_re),
        .i_rd_addr (store_rd_addr),
        .o_rd_data (store_rd_data)
    );

    ptq_ram #(
        .WIDTH (AW + LW),
        .DEPTH (PACKET_SLOTS)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (slot_we),
        .i_wr_addr (r_tail),
        .i_wr_data ({part_start, part_inc}),
        .i_rd_en   (slot_re),
        .i_rd_addr (r_head),
        .o_rd_data (slot_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_EXEC;
            r_max       <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_wait      <= '0;
            r_wp        <= '0;
            r_part      <= '0;
            r_used      <= '0;
            r_busy      <= 1'b0;
            r_cur_start <= '0;
            r_cur_len   <= '0;
            r_cur_off   <= '0;
            r_push      <= '0;
            r_pop       <= '0;
            r_fail      <= '0;
            r_peak      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max <= i_cfg_wr_data;
            end
            unique case (r_state)
                BS_EXEC: if (issue) r_state <= BS_FIN;
                BS_FIN:  if (out_free) r_state <= BS_EXEC;
                default: r_state <= BS_EXEC;
            endcase
            if (commit) begin
                r_head      <= n_head;
                r_tail      <= n_tail;
                r_wait      <= n_wait;
                r_wp        <= n_wp;
                r_part      <= n_part;
                r_used      <= n_used;
                r_busy      <= n_busy;
                r_cur_start <= n_cur_start;
                r_cur_len   <= n_cur_len;
                r_cur_off   <= n_cur_off;
                r_push      <= n_push;
                r_pop       <= n_pop;
                r_fail      <= n_fail;
                r_peak      <= n_peak;
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
        if (issue) begin
            r_cmd <= i_q_cmd;
        end
        if (commit) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// ----- rtl/packet_tx_queue.sv -----
// path: front register, command queue, result register; start send while
// idle with a packet waiting, a send tick that delivers a byte and tx done
// while busy with packets waiting also wait on the registered read of the
// byte store or packet slot memory, and hold off the next beat meanwhile
// throughput: one beat per cycle when no read is due and results are taken
// reset: sync active low, clears pointers, counters, flags and max_packets only
module packet_tx_queue #(
    parameter int PACKET_SLOTS = 16,
    parameter int STORE_BYTES  = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration: max_packets
    input  logic                               i_cfg_wr_en,
    input  logic [ptq_pkg::MAXP_W-1:0]         i_cfg_wr_data,
    // request beats
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [7:0] data_byte, [8] link_ok, [15:9] zero
    input  logic [ptq_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    input  logic                               i_s_axis_tlast,
    // [2:0] req_type
    input  logic [ptq_pkg::REQ_W-1:0]          i_s_axis_tuser,
    // result beats
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [4:0] packet_count, [5] none_waiting, [6] tx_busy, [14:7] out_byte,
    // [15] out_valid, [47:16] push_total, [79:48] pop_total,
    // [111:80] fail_total, [116:112] peak_packets, [119:117] zero
    output logic [ptq_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    output logic                               o_m_axis_tlast,
    // [1:0] status
    output logic [ptq_pkg::STAT_W-1:0]         o_m_axis_tuser
);

    import ptq_pkg::*;

    // front register to queue
    logic    front_valid;
    t_cmd    front_cmd;
    logic    q_in_ready;
    // queue to back end
    logic    q_valid;
    t_cmd    q_cmd;
    logic    q_pop;
    // back end result
    t_result res;

    // front: takes request beats and decodes them into commands
    ptq_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tlast  (i_s_axis_tlast),
        .i_s_tuser  (i_s_axis_tuser),
        .o_valid    (front_valid),
        .o_cmd      (front_cmd),
        .i_ready    (q_in_ready)
    );

    // short command queue, lets the front keep taking beats while the back stalls
    ptq_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (front_valid),
        .i_cmd       (front_cmd),
        .o_in_ready  (q_in_ready),
        .i_pop       (q_pop),
        .o_cmd       (q_cmd),
        .o_out_valid (q_valid)
    );

    // back: owns the byte store, packet slots, statistics and the result register
    ptq_back #(
        .PACKET_SLOTS (PACKET_SLOTS),
        .STORE_BYTES  (STORE_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_valid     (q_valid),
        .i_q_cmd       (q_cmd),
        .o_q_pop       (q_pop),
        .o_res_valid   (o_m_axis_tvalid),
        .i_res_ready   (i_m_axis_tready),
        .o_res         (res)
    );

    // pack result fields, highest field first
    assign o_m_axis_tdata = {3'b000,
                             res.peak_packets,
                             res.fail_total,
                             res.pop_total,
                             res.push_total,
                             res.out_valid,
                             res.out_byte,
                             res.tx_busy,
                             res.none_waiting,
                             res.packet_count};
    assign o_m_axis_tlast = res.out_last;
    assign o_m_axis_tuser = res.status;

endmodule

// ----- rtl/ptq_checker.sv -----
module ptq_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_m_axis_tvalid,
    input logic                               i_m_axis_tready,
    input logic [ptq_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    input logic                               o_m_axis_tlast,
    input logic [ptq_pkg::STAT_W-1:0]         o_m_axis_tuser
);

    import ptq_pkg::*;

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result beat right after reset");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("stalled result beat changed");

    // last marker only on a delivered byte
    a_last_on_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tdata[15])
        else $error("last marker without packet byte");

    // a delivered byte means status ok while busy
    a_byte_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[15] |->
            o_m_axis_tdata[6] && (o_m_axis_tuser == STAT_OK))
        else $error("packet byte while idle or with bad status");

    // no byte means a zero byte field
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[15] |->
            (o_m_axis_tdata[14:7] == 8'd0) && !o_m_axis_tlast)
        else $error("byte field set without packet byte");

endmodule

bind packet_tx_queue ptq_checker u_ptq_checker (.*);

// ----- verif/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptq_pkg::*;

    localparam int SLOTS          = 16;
    localparam int STORE          = 1024;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_PAD      = 8;

    // request codes the block treats as no-ops
    localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

    typedef struct {
        logic [REQ_W-1:0]  op;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              link;
        bit                typed;
        t_result           want;
    } t_step_row;

    // dut signals
    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_cfg_wr_en     = 1'b0;
    logic [MAXP_W-1:0]      i_cfg_wr_data   = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata  = '0;
    logic                   i_s_axis_tlast  = 1'b0;
    logic [REQ_W-1:0]       i_s_axis_tuser  = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tlast;
    logic [STAT_W-1:0]      o_m_axis_tuser;

    // queue model state, updated on every accepted request beat
    logic [BYTE_W-1:0]  pq_store [STORE];
    logic [10:0]        pq_len [SLOTS];
    logic [9:0]         pq_start [SLOTS];
    logic [3:0]         pq_head      = '0;
    logic [3:0]         pq_tail      = '0;
    logic [COUNT_W-1:0] pq_waiting   = '0;
    logic [9:0]         pq_wptr      = '0;
    logic [10:0]        pq_partial   = '0;
    logic [10:0]        pq_used      = '0;
    logic               pq_busy      = 1'b0;
    logic [9:0]         pq_cur_start = '0;
    logic [10:0]        pq_cur_len   = '0;
    logic [10:0]        pq_cur_off   = '0;
    logic [TOTAL_W-1:0] pq_pushes    = '0;
    logic [TOTAL_W-1:0] pq_pops      = '0;
    logic [TOTAL_W-1:0] pq_fails     = '0;
    logic [COUNT_W-1:0] pq_peak      = '0;
    logic [MAXP_W-1:0]  pq_max       = '0;

    t_result expected_beats [$];
    int      mismatches  = 0;
    int      beats_sent  = 0;
    int      cycles      = 0;
    int      idle_pct    = 0;
    int      stall_pct   = 0;
    int      hold_req    = 0;
    int      hold_seen   = 0;
    int      hold_left   = 0;

    packet_tx_queue #(
        .PACKET_SLOTS (SLOTS),
        .STORE_BYTES  (STORE)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one request through the queue model, returns the result it should produce
    function automatic t_result advance_queue(logic [REQ_W-1:0] op, logic [BYTE_W-1:0] data,
                                              logic last, logic link);
        t_result     r;
        int          lim;
        logic [10:0] len;
        logic [9:0]  gap;
        logic [9:0]  addr;
        r = '0;
        r.status = STAT_NONE;
        case (op)
            REQ_PUSH: begin
                lim = (pq_max == 0 || int'(pq_max) > SLOTS) ? SLOTS : int'(pq_max);
                if (int'(pq_waiting) >= lim || int'(pq_used) + int'(pq_partial) >= STORE) begin
                    // partial packet thrown away, next byte starts over
                    pq_wptr    = pq_wptr - pq_partial[9:0];
                    pq_partial = '0;
                    pq_fails   = pq_fails + 1;
                    r.status   = STAT_REJECT;
                end else begin
                    pq_store[pq_wptr] = data;
                    pq_wptr    = pq_wptr + 1'b1;
                    pq_partial = pq_partial + 1'b1;
                    if (last) begin
                        pq_start[pq_tail] = pq_wptr - pq_partial[9:0];
                        pq_len[pq_tail]   = pq_partial;
                        pq_tail    = pq_tail + 1'b1;
                        pq_waiting = pq_waiting + 1'b1;
                        pq_used    = pq_used + pq_partial;
                        pq_partial = '0;
                        pq_pushes  = pq_pushes + 1;
                        if (pq_waiting > pq_peak) pq_peak = pq_waiting;
                    end
                    r.status = STAT_OK;
                end
            end
            REQ_START: begin
                if (!pq_busy && pq_waiting != 0) begin
                    len          = pq_len[pq_head];
                    pq_cur_start = pq_start[pq_head];
                    pq_head      = pq_head + 1'b1;
                    pq_waiting   = pq_waiting - 1'b1;
                    pq_pops      = pq_pops + 1;
                    if (link) begin
                        pq_busy    = 1'b1;
                        pq_cur_len = len;
                        pq_cur_off = '0;
                        r.status   = STAT_OK;
                    end else begin
                        // refused by the link: popped and freed at once
                        pq_used      = (pq_used >= len) ? pq_used - len : '0;
                        pq_cur_start = '0;
                        r.status     = STAT_DROP;
                    end
                end
            end
            REQ_TICK: begin
                if (pq_busy && pq_cur_off < pq_cur_len) begin
                    addr        = pq_cur_start + pq_cur_off[9:0];
                    r.out_byte  = pq_store[addr];
                    r.out_valid = 1'b1;
                    r.out_last  = (pq_cur_off + 11'd1 == pq_cur_len);
                    pq_cur_off  = pq_cur_off + 1'b1;
                    r.status    = STAT_OK;
                end
            end
            REQ_DONE: begin
                if (pq_busy) begin
                    if (pq_waiting == 0) begin
                        pq_used = '0;
                    end else begin
                        // frees everything up to the next waiting packet
                        gap     = pq_start[pq_head] - pq_cur_start;
                        pq_used = (pq_used >= 11'(gap)) ? pq_used - 11'(gap) : '0;
                    end
                    pq_busy      = 1'b0;
                    pq_cur_start = '0;
                    pq_cur_len   = '0;
                    pq_cur_off   = '0;
                    r.status     = STAT_OK;
                end
            end
            REQ_FLUSH: begin
                pq_pops    = pq_pops + 32'(pq_waiting);
                pq_waiting = '0;
                pq_head    = pq_tail;
                if (!pq_busy) pq_used = '0;
                r.status = STAT_OK;
            end
            REQ_CLEAR: begin
                pq_pushes = '0;
                pq_pops   = '0;
                pq_fails  = '0;
                pq_peak   = '0;
                r.status  = STAT_OK;
            end
            default: ;
        endcase
        r.packet_count = pq_waiting;
        r.none_waiting = (pq_waiting == 0);
        r.tx_busy      = pq_busy;
        r.push_total   = pq_pushes;
        r.pop_total    = pq_pops;
        r.fail_total   = pq_fails;
        r.peak_packets = pq_peak;
        return r;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic put_beat(logic [REQ_W-1:0] op, logic [BYTE_W-1:0] data, logic last,
                            logic link, bit typed = 1'b0, t_result want = '0);
        t_result predicted;
        while ($urandom_range(99) < idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {7'd0, link, data};
        i_s_axis_tlast  <= last;
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predicted = advance_queue(op, data, last, link);
        expected_beats.push_back(typed ? want : predicted);
        beats_sent++;
        @(negedge i_clk);
    endtask

    // quiet the request side and let every pending result come back
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(negedge i_clk);
    endtask

    task automatic write_max_packets(logic [MAXP_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        pq_max = value;
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic push_packet(int len);
        for (int i = 0; i < len; i++) begin
            // now and then the last marker goes missing and packets run together
            put_beat(REQ_PUSH, 8'($urandom), (i == len - 1) && ($urandom_range(9) != 0),
                     1'($urandom));
        end
    endtask

    task automatic send_packet();
        int remaining;
        int ticks;
        put_beat(REQ_START, 8'($urandom), 1'($urandom), $urandom_range(99) < 85);
        remaining = pq_busy ? int'(pq_cur_len) - int'(pq_cur_off) : 0;
        case ($urandom_range(9))
            0:       ticks = remaining + 1;                 // runs past the end
            1:       ticks = $urandom_range(remaining);     // cut short
            default: ticks = remaining;
        endcase
        repeat (ticks) put_beat(REQ_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
        // sometimes tx done never comes and the next start finds the block busy
        if ($urandom_range(19) != 0)
            put_beat(REQ_DONE, 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // mostly well-formed packet traffic, with flushes, stat clears and raw noise
    task automatic run_traffic(int n_items, bit bulk);
        int first;
        int pick;
        first = beats_sent;
        while (beats_sent - first < n_items) begin
            pick = $urandom_range(99);
            if (bulk) begin
                // long packets, few sends: byte store runs out
                if (pick < 90) push_packet($urandom_range(60, 100));
                else send_packet();
            end else if (pick < 35) begin
                push_packet(($urandom_range(9) == 0) ? $urandom_range(7, 24)
                                                     : $urandom_range(1, 6));
            end else if (pick < 72) begin
                send_packet();
            end else if (pick < 76) begin
                put_beat(REQ_FLUSH, 8'($urandom), 1'($urandom), 1'($urandom));
            end else if (pick < 79) begin
                put_beat(REQ_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom));
            end else begin
                put_beat(3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
            end
        end
    endtask

    // result side: random stalls plus an occasional long hold-off
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_beats.size() == 0) begin
                $error("result beat with nothing expected");
                mismatches++;
            end else begin
                want = expected_beats.pop_front();
                check_field("status",       32'(want.status),       32'(o_m_axis_tuser));
                check_field("packet_count", 32'(want.packet_count), 32'(o_m_axis_tdata[4:0]));
                check_field("none_waiting", 32'(want.none_waiting), 32'(o_m_axis_tdata[5]));
                check_field("tx_busy",      32'(want.tx_busy),      32'(o_m_axis_tdata[6]));
                check_field("out_byte",     32'(want.out_byte),     32'(o_m_axis_tdata[14:7]));
                check_field("out_valid",    32'(want.out_valid),    32'(o_m_axis_tdata[15]));
                check_field("out_last",     32'(want.out_last),     32'(o_m_axis_tlast));
                check_field("push_total",   want.push_total,        o_m_axis_tdata[47:16]);
                check_field("pop_total",    want.pop_total,         o_m_axis_tdata[79:48]);
                check_field("fail_total",   want.fail_total,        o_m_axis_tdata[111:80]);
                check_field("peak_packets", 32'(want.peak_packets),
                            32'(o_m_axis_tdata[116:112]));
            end
        end
    end

    initial begin
        t_step_row plan [$];
        t_step_row row;
        t_result   idle_none;
        t_result   ok_empty;
        t_result   one_waiting;

        // results that follow directly from reset
        idle_none              = '0;
        idle_none.status       = STAT_NONE;
        idle_none.none_waiting = 1'b1;
        ok_empty               = idle_none;
        ok_empty.status        = STAT_OK;
        one_waiting              = '0;
        one_waiting.status       = STAT_OK;
        one_waiting.packet_count = 5'd1;
        one_waiting.push_total   = 32'd1;
        one_waiting.peak_packets = 5'd1;

        plan.push_back('{REQ_TICK,     8'h00, 1'b0, 1'b0, 1'b1, idle_none});   // tick while idle
        plan.push_back('{REQ_START,    8'h00, 1'b0, 1'b1, 1'b1, idle_none});   // start, empty
        plan.push_back('{REQ_DONE,     8'h00, 1'b0, 1'b0, 1'b1, idle_none});   // done while idle
        plan.push_back('{REQ_SPARE_LO, 8'h00, 1'b0, 1'b0, 1'b1, idle_none});
        plan.push_back('{REQ_SPARE_HI, 8'hff, 1'b1, 1'b1, 1'b1, idle_none});
        plan.push_back('{REQ_PUSH,     8'h00, 1'b0, 1'b1, 1'b1, ok_empty});
        plan.push_back('{REQ_PUSH,     8'hff, 1'b1, 1'b0, 1'b1, one_waiting});
        plan.push_back('{REQ_PUSH,     8'ha5, 1'b1, 1'b0, 1'b0, '0});          // one-byte packet
        plan.push_back('{REQ_START,    8'h00, 1'b0, 1'b1, 1'b0, '0});
        plan.push_back('{REQ_START,    8'h00, 1'b0, 1'b1, 1'b0, '0});          // start while busy
        plan.push_back('{REQ_TICK,     8'h00, 1'b0, 1'b0, 1'b0, '0});
        plan.push_back('{REQ_TICK,     8'h00, 1'b0, 1'b0, 1'b0, '0});          // final byte
        plan.push_back('{REQ_TICK,     8'h00, 1'b0, 1'b0, 1'b0, '0});          // past the end
        plan.push_back('{REQ_PUSH,     8'h5a, 1'b0, 1'b0, 1'b0, '0});          // partial packet
        plan.push_back('{REQ_FLUSH,    8'h00, 1'b0, 1'b0, 1'b0, '0});          // flush while busy
        plan.push_back('{REQ_PUSH,     8'h3c, 1'b1, 1'b0, 1'b0, '0});          // partial survived
        plan.push_back('{REQ_DONE,     8'h00, 1'b0, 1'b0, 1'b0, '0});
        plan.push_back('{REQ_START,    8'h00, 1'b0, 1'b0, 1'b0, '0});          // link refuses
        plan.push_back('{REQ_START,    8'h00, 1'b0, 1'b1, 1'b0, '0});
        plan.push_back('{REQ_PUSH,     8'h11, 1'b1, 1'b1, 1'b0, '0});
        plan.push_back('{REQ_FLUSH,    8'h00, 1'b0, 1'b0, 1'b0, '0});          // flush while idle
        plan.push_back('{REQ_CLEAR,    8'h00, 1'b0, 1'b0, 1'b0, '0});

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            row = plan[i];
            put_beat(row.op, row.data, row.last, row.link, row.typed, row.want);
        end
        drain();

        // single packet allowed, no idling
        write_max_packets(5'd1);
        run_traffic(200, 1'b0);
        drain();

        // full slot count, sender gaps
        idle_pct = 53;
        write_max_packets(5'd16);
        run_traffic(200, 1'b0);
        drain();

        // above the slot count acts as unlimited, receiver stalls
        idle_pct  = 0;
        stall_pct = 53;
        write_max_packets(5'd31);
        run_traffic(200, 1'b0);
        drain();

        // unlimited, long packets until the byte store overflows; the receiver
        // holds off at the start so the block backs up into its input
        idle_pct  = 23;
        stall_pct = 23;
        write_max_packets(5'd0);
        hold_req = hold_req + 1;
        run_traffic(900, 1'b1);
        drain();

        // random mid-range limit, back to full rate
        idle_pct  = 0;
        stall_pct = 0;
        write_max_packets(5'($urandom_range(2, 15)));
        run_traffic(250, 1'b0);
        drain();

        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ptq_pkg.sv
rtl/ptq_ram.sv
rtl/ptq_front.sv
rtl/ptq_queue.sv
rtl/ptq_back.sv
rtl/packet_tx_queue.sv
rtl/ptq_checker.sv
verif/tb.sv
